// ===== hw/rtl/rld_pkg.sv =====
// Shared types and constants for the UART line discipline rings.
// Holds command codes, character codes, the erase sequence and the result type.
// No dependencies.
package rld_pkg;

  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 3;
  localparam int RX_DEPTH_DEF = 256;
  localparam int TX_DEPTH_DEF = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE = 3'd0,
    CMD_TX_DONE = 3'd1,
    CMD_PUT     = 3'd2,
    CMD_GET     = 3'd3,
    CMD_PEEK    = 3'd4,
    CMD_SERVICE = 3'd5
  } rld_cmd_t;

  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DEL       = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_ESC       = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE     = 8'h7E;

  localparam int ERASE_LEN = 7;
  localparam int ERASE_IW  = $clog2(ERASE_LEN);

  // Cursor back one column, then clear to end of line.
  localparam logic [BYTE_W-1:0] ERASE_SEQ [ERASE_LEN] = '{
    CH_ESC, 8'h5B, 8'h31, 8'h44, CH_ESC, 8'h5B, 8'h4B
  };

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
  } rld_req_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_data;
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
    logic              has_line;
    logic              rx_empty;
    logic              tx_busy;
  } rld_result_t;

endpackage

// ===== hw/rtl/rld_ifs.sv =====
// Channel interfaces for the UART line discipline rings.
// Request, result and configuration channels with valid/ready handshakes.
// No dependencies.
interface rld_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data;
  modport source (output valid, output cmd, output data, input ready);
  modport sink (input valid, input cmd, input data, output ready);
endinterface

interface rld_rsp_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_data;
  logic       read_valid;
  logic [7:0] read_data;
  logic       has_line;
  logic       rx_empty;
  logic       tx_busy;
  modport source (output valid, output tx_valid, output tx_data, output read_valid,
                  output read_data, output has_line, output rx_empty, output tx_busy,
                  input ready);
  modport sink (input valid, input tx_valid, input tx_data, input read_valid,
                input read_data, input has_line, input rx_empty, input tx_busy,
                output ready);
endinterface

interface rld_cfg_if;
  logic valid;
  logic ready;
  logic loopback_enable;
  modport source (output valid, output loopback_enable, input ready);
  modport sink (input valid, input loopback_enable, output ready);
endinterface

// ===== hw/rtl/rld_ram.sv =====
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the receive and transmit rings; depends on rld_pkg for the default width.
module rld_ram import rld_pkg::*; #(
  parameter int DEPTH = RX_DEPTH_DEF,
  parameter int WIDTH = BYTE_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rld_core.sv =====
// Ring pointer and command sequencer for the UART line discipline.
// Reads, modifies and writes the two ring memories, one command at a time.
// Depends on rld_pkg and rld_ram.
module rld_core import rld_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  rld_req_t    req,
  input  logic        loopback,
  input  logic        res_ready,
  output logic        idle,
  output logic        res_valid,
  output rld_result_t res
);

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam int CW  = $clog2(RX_DEPTH);
  localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);
  localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RX_STORE, S_RX_DEL, S_RX_READ, S_TX_PUSH, S_TX_START, S_TX_READ, S_DONE
  } state_t;

  function automatic logic [RPW-1:0] rx_next(input logic [RPW-1:0] p);
    return (p == RX_LAST) ? '0 : p + RPW'(1);
  endfunction

  function automatic logic [RPW-1:0] rx_prev(input logic [RPW-1:0] p);
    return (p == '0) ? RX_LAST : p - RPW'(1);
  endfunction

  function automatic logic [TPW-1:0] tx_next(input logic [TPW-1:0] p);
    return (p == TX_LAST) ? '0 : p + TPW'(1);
  endfunction

  state_t              state, state_next;
  logic [RPW-1:0]      rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [CW-1:0]       rx_count, rx_count_next;
  logic [TPW-1:0]      tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic                tx_active, tx_active_next;
  logic [BYTE_W-1:0]   byte_r, byte_next;
  logic                is_get, is_get_next;
  logic                seq_erase, seq_erase_next;
  logic                seq_start, seq_start_next;
  logic [ERASE_IW-1:0] seq_idx, seq_idx_next;
  logic                tx_valid, tx_valid_next;
  logic [BYTE_W-1:0]   tx_data, tx_data_next;
  logic                read_valid, read_valid_next;
  logic [BYTE_W-1:0]   read_data, read_data_next;

  logic              rx_we, tx_we;
  logic [RPW-1:0]    rx_waddr, rx_raddr;
  logic [TPW-1:0]    tx_waddr, tx_raddr;
  logic [BYTE_W-1:0] rx_wdata, rx_rdata, tx_wdata, tx_rdata;
  logic [CW:0]       lf_tmp;
  logic              b_is_lf, b_is_del, b_ctrl, b_printable, b_store;
  logic [BYTE_W-1:0] push_byte;
  logic              push_last;

  rld_ram #(.DEPTH(RX_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
    .raddr(rx_raddr), .rdata(rx_rdata)
  );

  rld_ram #(.DEPTH(TX_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
    .raddr(tx_raddr), .rdata(tx_rdata)
  );

  assign b_is_lf     = (byte_r == CH_LF);
  assign b_is_del    = (byte_r == CH_DEL);
  assign b_ctrl      = (byte_r < CH_SPACE) || b_is_del;
  assign b_printable = (byte_r >= CH_SPACE) && (byte_r <= CH_TILDE);
  assign b_store     = !b_ctrl || b_is_lf;

  assign push_byte = seq_erase ? ERASE_SEQ[seq_idx] : ((seq_idx == '0) ? byte_r : CH_CR);
  assign push_last = seq_erase ? (seq_idx == ERASE_IW'(ERASE_LEN - 1))
                               : ((seq_idx != '0) || !b_is_lf);

  always_comb begin
    state_next      = state;
    rx_head_next    = rx_head;
    rx_tail_next    = rx_tail;
    rx_count_next   = rx_count;
    tx_head_next    = tx_head;
    tx_tail_next    = tx_tail;
    tx_active_next  = tx_active;
    byte_next       = byte_r;
    is_get_next     = is_get;
    seq_erase_next  = seq_erase;
    seq_start_next  = seq_start;
    seq_idx_next    = seq_idx;
    tx_valid_next   = tx_valid;
    tx_data_next    = tx_data;
    read_valid_next = read_valid;
    read_data_next  = read_data;
    rx_we           = 1'b0;
    rx_waddr        = rx_head;
    rx_wdata        = byte_r;
    rx_raddr        = rx_tail;
    tx_we           = 1'b0;
    tx_waddr        = tx_head;
    tx_wdata        = push_byte;
    tx_raddr        = tx_tail;
    lf_tmp          = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          tx_valid_next   = 1'b0;
          tx_data_next    = '0;
          read_valid_next = 1'b0;
          read_data_next  = '0;
          byte_next       = req.data;
          is_get_next     = (rld_cmd_t'(req.cmd) == CMD_GET);
          seq_erase_next  = 1'b0;
          seq_start_next  = 1'b0;
          seq_idx_next    = '0;
          case (rld_cmd_t'(req.cmd))
            CMD_RX_BYTE: begin
              if (req.data == CH_CR) begin
                byte_next = CH_LF;
              end
              state_next = S_RX_STORE;
            end
            CMD_TX_DONE: begin
              if (tx_active && (tx_head != tx_tail)) begin
                tx_tail_next = tx_next(tx_tail);
                state_next   = S_TX_READ;
              end else begin
                tx_active_next = 1'b0;
                state_next     = S_DONE;
              end
            end
            CMD_PUT: begin
              seq_start_next = 1'b1;
              state_next     = S_TX_PUSH;
            end
            CMD_GET, CMD_PEEK: begin
              state_next = (rx_head != rx_tail) ? S_RX_READ : S_DONE;
            end
            CMD_SERVICE: begin
              state_next = S_TX_START;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_RX_STORE: begin
        if (b_store) begin
          rx_we        = 1'b1;
          rx_head_next = rx_next(rx_head);
          lf_tmp       = {1'b0, rx_count} + (CW + 1)'(b_is_lf);
          if (rx_next(rx_head) == rx_tail) begin
            rx_tail_next = rx_next(rx_tail);
            if ((rx_rdata == CH_LF) && (lf_tmp != '0)) begin
              lf_tmp = lf_tmp - (CW + 1)'(1);
            end
          end
          rx_count_next = lf_tmp[CW-1:0];
        end
        state_next = S_DONE;
        if (loopback && (b_printable || b_is_lf)) begin
          state_next = S_TX_PUSH;
        end else if (loopback && b_is_del && (rx_head != rx_tail)) begin
          rx_head_next   = rx_prev(rx_head);
          rx_raddr       = rx_prev(rx_head);
          seq_erase_next = 1'b1;
          seq_start_next = 1'b1;
          state_next     = S_RX_DEL;
        end
      end
      S_RX_DEL: begin
        if ((rx_rdata == CH_LF) && (rx_count != '0)) begin
          rx_count_next = rx_count - CW'(1);
        end
        state_next = S_TX_PUSH;
      end
      S_RX_READ: begin
        read_valid_next = 1'b1;
        read_data_next  = rx_rdata;
        if (is_get) begin
          if ((rx_rdata == CH_LF) && (rx_count != '0)) begin
            rx_count_next = rx_count - CW'(1);
          end
          rx_tail_next = rx_next(rx_tail);
        end
        state_next = S_DONE;
      end
      S_TX_PUSH: begin
        tx_we        = 1'b1;
        tx_head_next = tx_next(tx_head);
        if (tx_next(tx_head) == tx_tail) begin
          tx_tail_next = tx_next(tx_tail);
        end
        seq_idx_next = seq_idx + ERASE_IW'(1);
        if (push_last) begin
          state_next = seq_start ? S_TX_START : S_DONE;
        end
      end
      S_TX_START: begin
        if (!tx_active && (tx_head != tx_tail)) begin
          tx_active_next = 1'b1;
          tx_tail_next   = tx_next(tx_tail);
          state_next     = S_TX_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TX_READ: begin
        tx_valid_next = 1'b1;
        tx_data_next  = tx_rdata;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rx_head   <= '0;
      rx_tail   <= '0;
      rx_count  <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      tx_active <= 1'b0;
    end else begin
      state     <= state_next;
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      rx_count  <= rx_count_next;
      tx_head   <= tx_head_next;
      tx_tail   <= tx_tail_next;
      tx_active <= tx_active_next;
    end
    byte_r     <= byte_next;
    is_get     <= is_get_next;
    seq_erase  <= seq_erase_next;
    seq_start  <= seq_start_next;
    seq_idx    <= seq_idx_next;
    tx_valid   <= tx_valid_next;
    tx_data    <= tx_data_next;
    read_valid <= read_valid_next;
    read_data  <= read_data_next;
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.tx_valid   = tx_valid;
    res.tx_data    = tx_data;
    res.read_valid = read_valid;
    res.read_data  = read_data;
    res.has_line   = (rx_count != '0);
    res.rx_empty   = (rx_head == rx_tail);
    res.tx_busy    = tx_active;
  end

endmodule

// ===== hw/rtl/uart_line_discipline_rings.sv =====
// Each request transaction produces exactly one result transaction. The block takes
// a request only while its sequencer is idle. The time from acceptance to result grows
// with each registered ring memory read and each byte written into the transmit ring,
// so a DEL erase with loopback, which queues seven bytes and starts the transmitter,
// is the longest case. A command that touches neither ring memory, such as an unused
// code, a get or peek on an empty ring or a transmit done with nothing queued, is the
// shortest. A finished result waits in an output register, so the next request is
// taken while it is still pending. Both rings come up empty after reset with no
// clearing pass. The loopback register is written over its own channel; the user must
// write it only while idle, as the block itself does not enforce this.
// Depends on rld_pkg, rld_ifs and rld_core.
module uart_line_discipline_rings import rld_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  rld_req_if.sink   req,
  rld_rsp_if.source rsp,
  rld_cfg_if.sink   cfg
);

  logic        loopback;
  logic        core_idle;
  logic        core_res_valid;
  logic        core_res_ready;
  logic        out_valid;
  rld_result_t core_res;
  rld_result_t out_res;
  rld_req_t    core_req;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loopback <= 1'b0;
    end else if (cfg.valid) begin
      loopback <= cfg.loopback_enable;
    end
  end

  assign core_req.cmd  = req.cmd;
  assign core_req.data = req.data;
  assign req.ready     = core_idle;

  assign core_res_ready = !out_valid || rsp.ready;

  rld_core #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_core (
    .clk(clk),
    .rst(rst),
    .start(req.valid && core_idle),
    .req(core_req),
    .loopback(loopback),
    .res_ready(core_res_ready),
    .idle(core_idle),
    .res_valid(core_res_valid),
    .res(core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_res_valid && core_res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (core_res_valid && core_res_ready) begin
      out_res <= core_res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.tx_valid   = out_res.tx_valid;
  assign rsp.tx_data    = out_res.tx_data;
  assign rsp.read_valid = out_res.read_valid;
  assign rsp.read_data  = out_res.read_data;
  assign rsp.has_line   = out_res.has_line;
  assign rsp.rx_empty   = out_res.rx_empty;
  assign rsp.tx_busy    = out_res.tx_busy;

endmodule
